[sv/drd_pkg.sv]
`timescale 1ns / 1ps
package drd_pkg;

  // Field widths
  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int PIX_W   = 14;
  localparam int LABEL_W = 7;
  localparam int CONF_W  = 16;
  localparam int THR_W   = 16;
  localparam int SIZE_W  = 13;
  localparam int CFG_W   = 16;
  localparam int NUM_W   = 34;   // 2*centre - size, before scaling
  localparam int PROD_W  = 64;   // score times objectness
  localparam int SCALE_W = 48;   // NUM_W times the zero-extended size

  // Row layout
  localparam int BOX_COUNT   = 4;
  localparam int OBJ_POS     = 4;
  localparam int FIRST_CLASS = 5;

  // Q16.16 fraction bits, plus one more for the halved size in a corner
  localparam int SIZE_SHIFT   = 16;
  localparam int CORNER_SHIFT = 17;

  // Pixel saturation
  localparam logic signed [PIX_W-1:0] PIX_MAX = 14'sd8191;
  localparam logic signed [PIX_W-1:0] PIX_MIN = -14'sd8192;
  localparam logic [CONF_W-1:0]       CONF_MAX = 16'hFFFF;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  // Register reset values
  localparam logic [THR_W-1:0]  OBJ_THR_RST = 16'd26214;
  localparam logic [THR_W-1:0]  CLS_THR_RST = 16'd32768;
  localparam logic [SIZE_W-1:0] IMG_W_RST   = 13'd640;
  localparam logic [SIZE_W-1:0] IMG_H_RST   = 13'd640;

  typedef enum logic [1:0] {
    CFG_OBJ_THR = 2'd0,
    CFG_CLS_THR = 2'd1,
    CFG_IMG_W   = 2'd2,
    CFG_IMG_H   = 2'd3
  } cfg_index_e;

  // One detection waiting for box scaling
  typedef struct packed {
    logic signed [NUM_W-1:0]   nx;
    logic signed [NUM_W-1:0]   ny;
    logic signed [VALUE_W-1:0] w;
    logic signed [VALUE_W-1:0] h;
    logic [LABEL_W-1:0]        label;
    logic [CONF_W-1:0]         conf;
  } drd_det_t;

endpackage

[sv/drd_front.sv]
`timescale 1ns / 1ps
module drd_front #(
  parameter int ROW_LENGTH = 85
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [drd_pkg::VALUE_W-1:0] in_value_i,
  input  logic [drd_pkg::THR_W-1:0]  obj_thr_i,
  input  logic [drd_pkg::THR_W-1:0]  cls_thr_i,
  input  logic [drd_pkg::CNT_W-1:0]  q_count_i,
  output logic                       push_o,
  output drd_pkg::drd_det_t          push_data_o
);
  import drd_pkg::*;

  logic                      in_fire;
  logic [POS_W-1:0]          pos_q;
  logic signed [VALUE_W-1:0] box_q [BOX_COUNT];
  logic signed [VALUE_W-1:0] obj_q;
  logic                      pass_q;
  logic signed [VALUE_W-1:0] value;
  logic                      is_score;

  logic                      s1_v_q;
  logic signed [VALUE_W-1:0] s1_score_q;
  logic signed [NUM_W-1:0]   s1_nx_q, s1_ny_q;
  logic signed [VALUE_W-1:0] s1_w_q, s1_h_q;
  logic [LABEL_W-1:0]        s1_label_q;

  logic                      s2_v_q;
  logic signed [PROD_W-1:0]  s2_prod_q;
  logic signed [NUM_W-1:0]   s2_nx_q, s2_ny_q;
  logic signed [VALUE_W-1:0] s2_w_q, s2_h_q;
  logic [LABEL_W-1:0]        s2_label_q;

  logic signed [PROD_W-1:0]  cls_lim;
  logic [CNT_W-1:0]          occupancy;

  // Take a request only when the queue can hold everything in flight
  assign occupancy  = q_count_i + CNT_W'(s1_v_q) + CNT_W'(s2_v_q);
  assign in_ready_o = occupancy < CNT_W'(QUEUE_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;
  assign value      = $signed(in_value_i);
  assign is_score   = (pos_q >= POS_W'(FIRST_CLASS)) && pass_q;

  // Advance the row position, keep box and objectness
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      obj_q  <= '0;
      pass_q <= 1'b0;
    end else if (in_fire) begin
      if (pos_q == POS_W'(ROW_LENGTH - 1)) begin
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (pos_q == POS_W'(OBJ_POS)) begin
        obj_q  <= value;
        pass_q <= value > $signed({{(VALUE_W-THR_W){1'b0}}, obj_thr_i});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && (pos_q < POS_W'(BOX_COUNT))) begin
      box_q[pos_q[1:0]] <= value;
    end
  end

  // Stage 1: snapshot the score with the row's box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= in_fire && is_score;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_score) begin
      s1_score_q <= value;
      s1_nx_q    <= $signed({box_q[0], 1'b0}) - NUM_W'(box_q[2]);
      s1_ny_q    <= $signed({box_q[1], 1'b0}) - NUM_W'(box_q[3]);
      s1_w_q     <= box_q[2];
      s1_h_q     <= box_q[3];
      s1_label_q <= pos_q - LABEL_W'(FIRST_CLASS);
    end
  end

  // Stage 2: multiply score by objectness
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_prod_q  <= PROD_W'(s1_score_q) * PROD_W'(obj_q);
      s2_nx_q    <= s1_nx_q;
      s2_ny_q    <= s1_ny_q;
      s2_w_q     <= s1_w_q;
      s2_h_q     <= s1_h_q;
      s2_label_q <= s1_label_q;
    end
  end

  // Compare against the class threshold and push a detection
  assign cls_lim = $signed({{(PROD_W-THR_W-SIZE_SHIFT){1'b0}}, cls_thr_i,
                            {SIZE_SHIFT{1'b0}}});
  assign push_o  = s2_v_q && (s2_prod_q > cls_lim);

  always_comb begin
    push_data_o.nx    = s2_nx_q;
    push_data_o.ny    = s2_ny_q;
    push_data_o.w     = s2_w_q;
    push_data_o.h     = s2_h_q;
    push_data_o.label = s2_label_q;
    if (|s2_prod_q[PROD_W-1:SIZE_SHIFT+CONF_W]) begin
      push_data_o.conf = CONF_MAX;
    end else begin
      push_data_o.conf = s2_prod_q[SIZE_SHIFT +: CONF_W];
    end
  end

endmodule

[sv/drd_queue.sv]
`timescale 1ns / 1ps
module drd_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_valid_i,
  input  drd_pkg::drd_det_t         wr_data_i,
  output logic                      rd_valid_o,
  input  logic                      rd_ready_i,
  output drd_pkg::drd_det_t         rd_data_o,
  output logic [drd_pkg::CNT_W-1:0] count_o
);
  import drd_pkg::*;

  drd_det_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             rd_fire;

  assign rd_valid_o = count_q != '0;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  // Hold requests in order
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (rd_fire) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(wr_valid_i) - CNT_W'(rd_fire);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> count_q != CNT_W'(QUEUE_DEPTH))
    else $error("detection queue written while full");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CNT_W'($past(wr_valid_i))
                        - CNT_W'($past(rd_fire)))
    else $error("detection queue count out of step");

endmodule

[sv/drd_back.sv]
`timescale 1ns / 1ps
module drd_back #(
  parameter int MODEL_SIDE = 640
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  drd_pkg::drd_det_t           q_data_i,
  input  logic [drd_pkg::SIZE_W-1:0]  img_w_i,
  input  logic [drd_pkg::SIZE_W-1:0]  img_h_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [drd_pkg::PIX_W-1:0]   left_o,
  output logic [drd_pkg::PIX_W-1:0]   top_o,
  output logic [drd_pkg::PIX_W-1:0]   box_width_o,
  output logic [drd_pkg::PIX_W-1:0]   box_height_o,
  output logic [drd_pkg::LABEL_W-1:0] label_o,
  output logic [drd_pkg::CONF_W-1:0]  confidence_o
);
  import drd_pkg::*;

  // Quotients past the saturation point are flagged before the reciprocal step and saturated after it
  localparam int          DIV_N   = 26;
  localparam int          SIDE_L  = $clog2(MODEL_SIDE);
  localparam int          RSHIFT  = DIV_N + SIDE_L;
  localparam int          RECIP_W = DIV_N + 1;
  localparam int          P_W     = DIV_N + RECIP_W;
  localparam logic [63:0] RECIP   = ((64'd1 << RSHIFT) + 64'(MODEL_SIDE) - 64'd1)
                                    / 64'(MODEL_SIDE);
  localparam logic [63:0] CLIP    = 64'd8193 * 64'(MODEL_SIDE);
  localparam int          LANES   = 4;

  logic b1_v_q, b2_v_q, b3_v_q, out_v_q;
  logic b1_ready, b2_ready, b3_ready, out_ready;

  logic signed [SCALE_W-1:0] b1_t_q   [LANES];
  logic [LABEL_W-1:0]        b1_label_q, b2_label_q, b3_label_q;
  logic [CONF_W-1:0]         b1_conf_q, b2_conf_q, b3_conf_q;
  logic                      b2_neg_q [LANES];
  logic                      b2_big_q [LANES];
  logic [DIV_N-1:0]          b2_b_q   [LANES];
  logic                      b3_neg_q [LANES];
  logic                      b3_big_q [LANES];
  logic [P_W-1:0]            b3_p_q   [LANES];
  logic signed [PIX_W-1:0]   pix_q    [LANES];
  logic [LABEL_W-1:0]        out_label_q;
  logic [CONF_W-1:0]         out_conf_q;

  logic signed [NUM_W-1:0]   num   [LANES];
  logic [SIZE_W-1:0]         size  [LANES];
  logic [SCALE_W-1:0]        mag   [LANES];
  logic [SCALE_W-1:0]        shr   [LANES];
  logic [PIX_W-1:0]          quot  [LANES];
  logic signed [PIX_W-1:0]   pix_d [LANES];

  // Stall chain from the output register back to the queue
  assign out_ready = !out_v_q || out_ready_i;
  assign b3_ready  = !b3_v_q || out_ready;
  assign b2_ready  = !b2_v_q || b3_ready;
  assign b1_ready  = !b1_v_q || b2_ready;
  assign q_ready_o = b1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (b1_ready)  b1_v_q  <= q_valid_i;
      if (b2_ready)  b2_v_q  <= b1_v_q;
      if (b3_ready)  b3_v_q  <= b2_v_q;
      if (out_ready) out_v_q <= b3_v_q;
    end
  end

  // Lane order: left, top, width, height
  always_comb begin
    num[0]  = q_data_i.nx;
    num[1]  = q_data_i.ny;
    num[2]  = NUM_W'(q_data_i.w);
    num[3]  = NUM_W'(q_data_i.h);
    size[0] = img_w_i;
    size[1] = img_h_i;
    size[2] = img_w_i;
    size[3] = img_h_i;
  end

  // Stage 1: scale by target size
  always_ff @(posedge clk_i) begin
    if (q_valid_i && b1_ready) begin
      for (int i = 0; i < LANES; i++) begin
        b1_t_q[i] <= SCALE_W'(num[i]) * $signed({{(SCALE_W-SIZE_W){1'b0}}, size[i]});
      end
      b1_label_q <= q_data_i.label;
      b1_conf_q  <= q_data_i.conf;
    end
  end

  // Stage 2: magnitude, drop fraction bits, flag large values
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mag[i] = b1_t_q[i][SCALE_W-1] ? SCALE_W'(-b1_t_q[i]) : SCALE_W'(b1_t_q[i]);
      shr[i] = (i < 2) ? (mag[i] >> CORNER_SHIFT) : (mag[i] >> SIZE_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_v_q && b2_ready) begin
      for (int i = 0; i < LANES; i++) begin
        b2_neg_q[i] <= b1_t_q[i][SCALE_W-1];
        b2_big_q[i] <= shr[i] >= SCALE_W'(CLIP);
        b2_b_q[i]   <= shr[i][DIV_N-1:0];
      end
      b2_label_q <= b1_label_q;
      b2_conf_q  <= b1_conf_q;
    end
  end

  // Stage 3: divide by the model side through its reciprocal
  always_ff @(posedge clk_i) begin
    if (b2_v_q && b3_ready) begin
      for (int i = 0; i < LANES; i++) begin
        b3_neg_q[i] <= b2_neg_q[i];
        b3_big_q[i] <= b2_big_q[i];
        b3_p_q[i]   <= P_W'(b2_b_q[i]) * P_W'(RECIP[RECIP_W-1:0]);
      end
      b3_label_q <= b2_label_q;
      b3_conf_q  <= b2_conf_q;
    end
  end

  // Apply sign and saturate to the pixel range
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      quot[i] = b3_p_q[i][RSHIFT +: PIX_W];
      if (b3_neg_q[i]) begin
        if (b3_big_q[i] || (quot[i] >= PIX_W'(8192))) begin
          pix_d[i] = PIX_MIN;
        end else begin
          pix_d[i] = -$signed(quot[i]);
        end
      end else begin
        if (b3_big_q[i] || (quot[i] >= PIX_W'(8191))) begin
          pix_d[i] = PIX_MAX;
        end else begin
          pix_d[i] = $signed(quot[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_v_q && out_ready) begin
      for (int i = 0; i < LANES; i++) begin
        pix_q[i] <= pix_d[i];
      end
      out_label_q <= b3_label_q;
      out_conf_q  <= b3_conf_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign left_o       = pix_q[0];
  assign top_o        = pix_q[1];
  assign box_width_o  = pix_q[2];
  assign box_height_o = pix_q[3];
  assign label_o      = out_label_q;
  assign confidence_o = out_conf_q;

endmodule

[sv/detection_row_decoder.sv]
`timescale 1ns / 1ps
// Once its class score is accepted, a detection passes 3 front stages including the
//   queue write, 3 scaling stages, then the output register on the master side.
// Throughput: the front and the scaling pipeline each take one per cycle unless stalled.
// The four-entry detection queue plus the output register let each side stall on its own.
// Reset: asynchronous, active low; registers return to defaults, row position to zero,
//   queue and pipelines empty.
module detection_row_decoder #(
  parameter int ROW_LENGTH = 85,
  parameter int MODEL_SIDE = 640
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left[13:0], top[27:14], box_width[41:28], box_height[55:42],
  // label[62:56], confidence[78:63], zero[79]
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import drd_pkg::*;

  logic [THR_W-1:0]   obj_thr_q, cls_thr_q;
  logic [SIZE_W-1:0]  img_w_q, img_h_q;
  logic [CNT_W-1:0]   q_count;
  logic               push;
  drd_det_t           push_data;
  logic               q_valid, q_ready;
  drd_det_t           q_data;
  logic [PIX_W-1:0]   left, top, box_width, box_height;
  logic [LABEL_W-1:0] label;
  logic [CONF_W-1:0]  confidence;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_thr_q <= OBJ_THR_RST;
      cls_thr_q <= CLS_THR_RST;
      img_w_q   <= IMG_W_RST;
      img_h_q   <= IMG_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_addr_i))
        CFG_OBJ_THR: obj_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_CLS_THR: cls_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_IMG_W:   img_w_q   <= cfg_wdata_i[SIZE_W-1:0];
        CFG_IMG_H:   img_h_q   <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  drd_front #(
    .ROW_LENGTH(ROW_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .obj_thr_i   (obj_thr_q),
    .cls_thr_i   (cls_thr_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  drd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (push_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data),
    .count_o    (q_count)
  );

  drd_back #(
    .MODEL_SIDE(MODEL_SIDE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_data_i     (q_data),
    .img_w_i      (img_w_q),
    .img_h_i      (img_h_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .left_o       (left),
    .top_o        (top),
    .box_width_o  (box_width),
    .box_height_o (box_height),
    .label_o      (label),
    .confidence_o (confidence)
  );

  assign m_axis_tdata = {1'b0, confidence, label, box_height, box_width, top, left};

  a_conf_above_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> confidence >= cls_thr_q)
    else $error("detection confidence below class threshold");

  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> label <= LABEL_W'(ROW_LENGTH - FIRST_CLASS - 1))
    else $error("detection label outside class range");

endmodule

[test/detection_row_decoder_tb.sv]
`timescale 1ns / 1ps
module detection_row_decoder_tb;
  import drd_pkg::*;

  localparam int ROW_LENGTH     = 85;
  localparam int MODEL_SIDE     = 640;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_STALL_AT  = 200;
  localparam int LONG_STALL_LEN = 300;

  // One expected detection, at the output widths
  typedef struct packed {
    logic signed [PIX_W-1:0] left;
    logic signed [PIX_W-1:0] top;
    logic signed [PIX_W-1:0] box_w;
    logic signed [PIX_W-1:0] box_h;
    logic [LABEL_W-1:0]      label;
    logic [CONF_W-1:0]       conf;
  } det_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_wdata_i   = '0;

  logic [31:0] pending_values[$];
  det_t        expected_dets[$];

  // Decoder state mirrored for prediction
  int     obj_thr_cfg;
  int     cls_thr_cfg;
  int     img_w_cfg;
  int     img_h_cfg;
  int     row_pos    = 0;
  longint row_box[BOX_COUNT] = '{default: 0};
  longint row_obj    = 0;
  bit     row_counts = 1'b0;

  int sent_cnt;
  int rcv_cnt;
  int row_cnt;
  int err_cnt   = 0;
  int cycle_cnt = 0;
  int send_gap;
  int rcv_gap;
  int rcv_hold;
  int long_left;
  bit long_done;

  detection_row_decoder #(
    .ROW_LENGTH(ROW_LENGTH),
    .MODEL_SIDE(MODEL_SIDE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Scale a corner or size to pixels, truncate toward zero, saturate
  function automatic logic signed [PIX_W-1:0] scale_pixel(longint num, int size, int fac);
    longint den;
    longint q;
    den = longint'(fac) * MODEL_SIDE * 65536;
    q   = (num * longint'(size)) / den;
    if (q > 8191) q = 8191;
    if (q < -8192) q = -8192;
    return q[PIX_W-1:0];
  endfunction

  // Advance the row state by one value; return 1 when it yields a detection
  function automatic bit decode_value(logic [31:0] raw, output det_t det);
    longint v;
    longint prod;
    longint conf;
    bit     hit;
    v   = longint'($signed(raw));
    hit = 1'b0;
    det = '0;
    if (row_pos < BOX_COUNT) begin
      row_box[row_pos] = v;
    end else if (row_pos == OBJ_POS) begin
      row_obj    = v;
      row_counts = v > longint'(obj_thr_cfg);
    end else if (row_counts) begin
      prod = v * row_obj;
      if (prod > (longint'(cls_thr_cfg) << 16)) begin
        conf = prod >>> 16;
        if (conf > 65535) conf = 65535;
        det.left  = scale_pixel(2 * row_box[0] - row_box[2], img_w_cfg, 2);
        det.top   = scale_pixel(2 * row_box[1] - row_box[3], img_h_cfg, 2);
        det.box_w = scale_pixel(row_box[2], img_w_cfg, 1);
        det.box_h = scale_pixel(row_box[3], img_h_cfg, 1);
        det.label = LABEL_W'(row_pos - FIRST_CLASS);
        det.conf  = conf[CONF_W-1:0];
        hit = 1'b1;
      end
    end
    row_pos = (row_pos + 1 >= ROW_LENGTH) ? 0 : row_pos + 1;
    return hit;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Append one value to the send queue
  function automatic void add_value(logic [31:0] val);
    pending_values.insert(pending_values.size(), val);
  endfunction

  // Write one register at the next edge and mirror it
  task automatic write_reg(cfg_index_e idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[15:0];
    case (idx)
      CFG_OBJ_THR: obj_thr_cfg = val & 16'hFFFF;
      CFG_CLS_THR: cls_thr_cfg = val & 16'hFFFF;
      CFG_IMG_W:   img_w_cfg   = val & 13'h1FFF;
      CFG_IMG_H:   img_h_cfg   = val & 13'h1FFF;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int obj_thr, int cls_thr, int img_w, int img_h);
    write_reg(CFG_OBJ_THR, obj_thr);
    write_reg(CFG_CLS_THR, cls_thr);
    write_reg(CFG_IMG_W, img_w);
    write_reg(CFG_IMG_H, img_h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queue one row: a plausible detector row, or raw noise over all bits
  task automatic push_row(bit noise);
    int          obj;
    int          pick;
    logic [31:0] score;
    longint      edge_score;
    row_cnt++;
    if (noise) begin
      for (int k = 0; k < ROW_LENGTH; k++) add_value($urandom());
    end else begin
      add_value($urandom_range(0, 640 << 16));
      add_value($urandom_range(0, 640 << 16));
      add_value($urandom_range(0, 400 << 16));
      add_value($urandom_range(0, 400 << 16));
      pick = $urandom_range(0, 9);
      if (pick == 0) obj = obj_thr_cfg;
      else if (pick == 1) obj = $urandom_range(0, 65536);
      else if (pick == 2) obj = $urandom_range(65536, 1 << 20);
      else obj = $urandom_range(obj_thr_cfg + 1, 65536);
      add_value(obj);
      for (int k = FIRST_CLASS; k < ROW_LENGTH; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 5) score = $urandom_range(0, 65536);
        else if (pick == 6) score = -$urandom_range(1, 65536);
        else if (pick == 7) score = $urandom_range(65536, 1 << 24);
        else if (pick == 8) score = '0;
        else begin
          // land right on or just past the class threshold
          edge_score = (obj > 0) ? (longint'(cls_thr_cfg) << 16) / obj : 0;
          edge_score = edge_score + $urandom_range(0, 1);
          score = edge_score[31:0];
        end
        add_value(score);
      end
    end
  endtask

  // Hold until every value is taken and every detection has come back
  task automatic drain_all();
    while (pending_values.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_dets.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sender: offer queued values, predict on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    det_t det;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
      sent_cnt      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_value(s_axis_tdata, det)) begin
          expected_dets.insert(expected_dets.size(), det);
        end
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pending_values.size() != 0) begin
          s_axis_tdata  <= pending_values.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap      <= sent_cnt[6] ? 0 : $urandom_range(0, 4);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each detection, draw stalls, one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    det_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_cnt       <= 0;
      rcv_hold      <= 0;
      long_left     <= 0;
      long_done     <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rcv_cnt <= rcv_cnt + 1;
        if (expected_dets.size() == 0) begin
          $display("%0t: unexpected detection, expected none, actual %h", $time,
                   m_axis_tdata);
          err_cnt++;
        end else begin
          want = expected_dets.pop_front();
          check_field("left", want.left, $signed(m_axis_tdata[13:0]));
          check_field("top", want.top, $signed(m_axis_tdata[27:14]));
          check_field("box_width", want.box_w, $signed(m_axis_tdata[41:28]));
          check_field("box_height", want.box_h, $signed(m_axis_tdata[55:42]));
          check_field("label", want.label, m_axis_tdata[62:56]);
          check_field("confidence", want.conf, m_axis_tdata[78:63]);
          check_field("pad", 0, m_axis_tdata[79]);
        end
      end
      if (long_left != 0) begin
        m_axis_tready <= 1'b0;
        long_left     <= long_left - 1;
      end else if (!long_done && sent_cnt >= LONG_STALL_AT) begin
        m_axis_tready <= 1'b0;
        long_left     <= LONG_STALL_LEN;
        long_done     <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rcv_gap = rcv_cnt[5] ? 0 : $urandom_range(0, 4);
        m_axis_tready <= (rcv_gap == 0);
        rcv_hold      <= (rcv_gap == 0) ? 0 : rcv_gap - 1;
      end else if (rcv_hold != 0) begin
        m_axis_tready <= 1'b0;
        rcv_hold      <= rcv_hold - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [31:0] v;
    row_cnt     = 0;
    obj_thr_cfg = OBJ_THR_RST;
    cls_thr_cfg = CLS_THR_RST;
    img_w_cfg   = IMG_W_RST;
    img_h_cfg   = IMG_H_RST;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: extreme box values, threshold edges, saturated confidence
    for (int k = 0; k < ROW_LENGTH; k++) begin
      case (k)
        0, 2:    v = 32'h7FFF_FFFF;
        1, 3:    v = 32'h8000_0000;
        4:       v = 32'd65536;
        5:       v = 32'd32768;
        6:       v = 32'd32769;
        7:       v = 32'h7FFF_FFFF;
        8:       v = 32'h8000_0000;
        9:       v = 32'hFFFF_FFFF;
        10:      v = 32'd65536;
        84:      v = 32'd40000;
        default: v = '0;
      endcase
      add_value(v);
    end
    // Objectness equal to its threshold drops the whole row
    for (int k = 0; k < ROW_LENGTH; k++) begin
      case (k)
        0:       v = (320 << 16) + 32768;
        1:       v = 240 << 16;
        2:       v = (100 << 16) + 1;
        3:       v = 50 << 16;
        4:       v = 32'd26214;
        5:       v = 32'd65536;
        6:       v = 32'h7FFF_FFFF;
        default: v = '0;
      endcase
      add_value(v);
    end
    row_cnt = 2;
    drain_all();

    // Open thresholds, extreme image sizes; the long receiver stall lands here
    apply_settings(0, 0, 1, 4096);
    push_row(1'b0);
    push_row(1'b0);
    drain_all();

    apply_settings(65535, 65535, 4096, 1);
    push_row(1'b0);
    push_row(1'b1);
    drain_all();

    // Zero and full-field image sizes
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 8191);
    push_row(1'b0);
    push_row(1'b1);
    drain_all();

    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 4096), $urandom_range(1, 4096));
    push_row(1'b0);
    drain_all();

    $display("Fed %0d values in %0d rows under 5 register settings,", sent_cnt, row_cnt);
    $display("checked %0d detections, %0d mismatches", rcv_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
